@@ src/allan_deviation_six_axis_top_macros.svh @@
// assertion macros for the allan deviation rtl
`ifndef ALLAN_DEVIATION_SIX_AXIS_TOP_MACROS_SVH
`define ALLAN_DEVIATION_SIX_AXIS_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define ALD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ALD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ALD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ALD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ src/alldev_pkg.sv @@
// types and constants of the allan deviation block
`default_nettype none
package alldev_pkg;
    localparam int SAMPLE_BITS = 32;
    localparam int AXES        = 6;
    localparam int OUT_FIELDS  = 6;
    localparam int SUM_W       = SAMPLE_BITS + 16;
    localparam int SQ_W        = 64;
    localparam int ROOT_W      = 32;
    localparam int DIV_W       = 16;
    localparam int DIV_STEPS   = 64;
    localparam int ROOT_STEPS  = 32;
    localparam int STEP_W      = $clog2(DIV_STEPS);
    localparam int LEN_W       = 16;
    localparam int CNT_W       = 12;
    localparam int ADDR_W      = 3;
    localparam logic [ADDR_W-1:0] ADDR_LEN = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_CNT = 3'd4;
    localparam logic [LEN_W-1:0] LEN_RESET = 16'd100;
    localparam logic [CNT_W-1:0] CNT_RESET = 12'd2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_TAKE,
        OP_MLOAD,
        OP_DSTEP,
        OP_SQUARE,
        OP_ACCUM,
        OP_VLOAD,
        OP_RLOAD,
        OP_RSTEP,
        OP_CLEAR
    } lane_op_t;

    typedef struct packed {
        lane_op_t op;
        logic     restart;
        logic     first;
    } lane_ctrl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MLOAD,
        S_MDIV,
        S_SQUARE,
        S_ACCUM,
        S_VLOAD,
        S_VDIV,
        S_RLOAD,
        S_ROOT,
        S_OUT
    } state_t;
endpackage
`default_nettype wire

@@ src/alldev_if.sv @@
// valid/ready channels for samples and results
`default_nettype none
interface alldev_in_if;
    logic valid;
    logic ready;
    logic restart;
    logic [alldev_pkg::SAMPLE_BITS-1:0] accel_x;
    logic [alldev_pkg::SAMPLE_BITS-1:0] accel_y;
    logic [alldev_pkg::SAMPLE_BITS-1:0] accel_z;
    logic [alldev_pkg::SAMPLE_BITS-1:0] gyro_x;
    logic [alldev_pkg::SAMPLE_BITS-1:0] gyro_y;
    logic [alldev_pkg::SAMPLE_BITS-1:0] gyro_z;
    modport source (output valid, restart, accel_x, accel_y, accel_z,
                    gyro_x, gyro_y, gyro_z, input ready);
    modport sink (input valid, restart, accel_x, accel_y, accel_z,
                  gyro_x, gyro_y, gyro_z, output ready);
endinterface

interface alldev_out_if;
    logic valid;
    logic ready;
    logic [31:0] accel_std_x;
    logic [31:0] accel_std_y;
    logic [31:0] accel_std_z;
    logic [31:0] gyro_std_x;
    logic [31:0] gyro_std_y;
    logic [31:0] gyro_std_z;
    modport source (output valid, accel_std_x, accel_std_y, accel_std_z,
                    gyro_std_x, gyro_std_y, gyro_std_z, input ready);
    modport sink (input valid, accel_std_x, accel_std_y, accel_std_z,
                  gyro_std_x, gyro_std_y, gyro_std_z, output ready);
endinterface
`default_nettype wire

@@ src/alldev_lane.sv @@
// one axis: block sum, mean divide, squared difference, variance divide, square root
`default_nettype none
module alldev_lane (
    input  wire                         clk,
    input  wire                         rst_n,
    input  alldev_pkg::lane_ctrl_t      ctrl,
    input  alldev_pkg::sample_t         sample,
    input  wire [alldev_pkg::DIV_W-1:0] divisor,
    output logic [alldev_pkg::ROOT_W-1:0] root
);
    import alldev_pkg::*;

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [SUM_W-1:0] prev_reg, prev_next;
    logic [SQ_W-1:0]         sqsum_reg, sqsum_next;
    logic [SQ_W-1:0]         sq_reg;
    logic [SQ_W-1:0]         num_reg;
    logic [DIV_W-1:0]        rem_reg;
    logic                    neg_reg;
    logic [SQ_W-1:0]         x_reg, root_reg, bit_reg;

    logic [DIV_W:0]          rem_shift;
    logic                    rem_ge;
    logic [SUM_W-1:0]        sum_mag;
    logic signed [SUM_W-1:0] mean;
    logic signed [SUM_W:0]   diff;
    logic [SUM_W:0]          diff_mag;
    logic [SQ_W-1:0]         sq_val;
    logic [SQ_W:0]           sat_sum;
    logic [SQ_W-1:0]         trial;

    // restoring divider step, one quotient bit per cycle
    assign rem_shift = {rem_reg, num_reg[SQ_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, divisor};
    assign sum_mag   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : sum_reg;

    // signed mean and saturated square of the difference
    assign mean     = neg_reg ? SUM_W'(-num_reg[SUM_W-1:0]) : signed'(num_reg[SUM_W-1:0]);
    assign diff     = {mean[SUM_W-1], mean} - {prev_reg[SUM_W-1], prev_reg};
    assign diff_mag = diff[SUM_W] ? (SUM_W+1)'(-diff) : diff;
    assign sq_val   = (diff_mag[SUM_W:ROOT_W] != '0) ? {SQ_W{1'b1}}
                    : SQ_W'(diff_mag[ROOT_W-1:0] * diff_mag[ROOT_W-1:0]);
    assign sat_sum  = {1'b0, sqsum_reg} + {1'b0, sq_reg};

    // square root trial value
    assign trial = root_reg + bit_reg;

    // next analysis state
    always_comb
    begin
        sum_next   = sum_reg;
        prev_next  = prev_reg;
        sqsum_next = sqsum_reg;
        case (ctrl.op)
            OP_TAKE:
            begin
                sum_next = (ctrl.restart ? '0 : sum_reg) + SUM_W'(sample);
                if (ctrl.restart)
                begin
                    prev_next  = '0;
                    sqsum_next = '0;
                end
            end
            OP_SQUARE:
            begin
                prev_next = mean;
                sum_next  = '0;
            end
            OP_ACCUM:
            begin
                if (!ctrl.first)
                    sqsum_next = sat_sum[SQ_W] ? {SQ_W{1'b1}} : sat_sum[SQ_W-1:0];
            end
            OP_CLEAR:
            begin
                sum_next   = '0;
                prev_next  = '0;
                sqsum_next = '0;
            end
            default:
            begin
                sum_next = sum_reg;
            end
        endcase
    end

    // analysis state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            prev_reg  <= '0;
            sqsum_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            prev_reg  <= prev_next;
            sqsum_reg <= sqsum_next;
        end
    end

    // divider, square and root datapath
    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            OP_MLOAD:
            begin
                neg_reg <= sum_reg[SUM_W-1];
                num_reg <= SQ_W'(sum_mag);
                rem_reg <= '0;
            end
            OP_VLOAD:
            begin
                num_reg <= sqsum_reg;
                rem_reg <= '0;
            end
            OP_DSTEP:
            begin
                rem_reg <= rem_ge ? DIV_W'(rem_shift - {1'b0, divisor})
                                  : rem_shift[DIV_W-1:0];
                num_reg <= {num_reg[SQ_W-2:0], rem_ge};
            end
            OP_SQUARE:
            begin
                sq_reg <= sq_val;
            end
            OP_RLOAD:
            begin
                x_reg    <= num_reg;
                root_reg <= '0;
                bit_reg  <= SQ_W'(1) << (SQ_W - 2);
            end
            OP_RSTEP:
            begin
                if (x_reg >= trial)
                begin
                    x_reg    <= x_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            default:
            begin
                neg_reg <= neg_reg;
            end
        endcase
    end

    assign root = root_reg[ROOT_W-1:0];
endmodule
`default_nettype wire

@@ src/allan_deviation_six_axis_top.sv @@
// Non-overlapping Allan deviation over six IMU axes, one lane per axis.
// A sample that does not close a block is accepted in the idle state; one that closes a block
// runs the 64-step mean divider in each lane, and no sample is accepted until the block is folded in.
// Closing the last block adds the variance divide (64-step divider), the 32-step root and the result word.
// Reset (rst_n, async, low) clears all sums and counters; block_length 100, block_count 2.
`default_nettype none
module allan_deviation_six_axis_top (
    input  wire                          clk,
    input  wire                          rst_n,
    alldev_in_if.sink                    smp,
    alldev_out_if.source                 res,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [alldev_pkg::ADDR_W-1:0] paddr,
    input  wire [31:0]                   pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import alldev_pkg::*;
    `include "allan_deviation_six_axis_top_macros.svh"

    logic [LEN_W-1:0]  len_reg;
    logic [CNT_W-1:0]  cnt_reg;
    state_t            state_reg, state_next;
    logic [LEN_W-1:0]  sc_reg, sc_next;
    logic [CNT_W-1:0]  bc_reg, bc_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              res_valid_reg;
    logic [ROOT_W-1:0] std_reg [OUT_FIELDS];

    logic [LEN_W-1:0]  len_eff;
    logic [CNT_W-1:0]  blocks_eff;
    logic [DIV_W-1:0]  divisor;
    logic [LEN_W-1:0]  sc_inc;
    logic [CNT_W-1:0]  bc_inc;
    logic              accept;
    logic              out_free;
    lane_ctrl_t        ctrl;
    sample_t           samples [OUT_FIELDS];
    logic [ROOT_W-1:0] roots [AXES];

    // configuration port
    assign pready = 1'b1;
    always_comb
    begin
        case (paddr)
            ADDR_LEN: prdata = 32'(len_reg);
            ADDR_CNT: prdata = 32'(cnt_reg);
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_RESET;
            cnt_reg <= CNT_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == ADDR_LEN)
                len_reg <= pwdata[LEN_W-1:0];
            if (paddr == ADDR_CNT)
                cnt_reg <= pwdata[CNT_W-1:0];
        end
    end

    // effective block length, block count and divisor
    assign len_eff    = (len_reg == '0) ? LEN_W'(1) : len_reg;
    assign blocks_eff = (cnt_reg < CNT_W'(2)) ? CNT_W'(2) : cnt_reg;
    assign divisor    = (state_reg == S_VDIV) ? DIV_W'({blocks_eff - CNT_W'(1), 1'b0})
                                              : DIV_W'(len_eff);

    assign accept   = smp.valid && smp.ready;
    assign out_free = !res_valid_reg || res.ready;
    assign sc_inc   = (smp.restart ? '0 : sc_reg) + LEN_W'(1);
    assign bc_inc   = bc_reg + CNT_W'(1);

    // next state and counters
    always_comb
    begin
        state_next = state_reg;
        sc_next    = sc_reg;
        bc_next    = bc_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sc_next = sc_inc;
                    if (smp.restart)
                        bc_next = '0;
                    if (sc_inc >= len_eff)
                        state_next = S_MLOAD;
                end
            end
            S_MLOAD:
            begin
                step_next  = '0;
                state_next = S_MDIV;
            end
            S_MDIV:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = S_SQUARE;
            end
            S_SQUARE:
            begin
                sc_next    = '0;
                state_next = S_ACCUM;
            end
            S_ACCUM:
            begin
                bc_next    = bc_inc;
                state_next = (bc_inc >= blocks_eff) ? S_VLOAD : S_IDLE;
            end
            S_VLOAD:
            begin
                step_next  = '0;
                state_next = S_VDIV;
            end
            S_VDIV:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = S_RLOAD;
            end
            S_RLOAD:
            begin
                step_next  = '0;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(ROOT_STEPS - 1))
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    sc_next    = '0;
                    bc_next    = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // lane commands and input ready
    always_comb
    begin
        ctrl.restart = smp.restart;
        ctrl.first   = (bc_reg == '0);
        smp.ready    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                smp.ready = 1'b1;
                ctrl.op   = accept ? OP_TAKE : OP_NONE;
            end
            S_MLOAD:  ctrl.op = OP_MLOAD;
            S_MDIV:   ctrl.op = OP_DSTEP;
            S_SQUARE: ctrl.op = OP_SQUARE;
            S_ACCUM:  ctrl.op = OP_ACCUM;
            S_VLOAD:  ctrl.op = OP_VLOAD;
            S_VDIV:   ctrl.op = OP_DSTEP;
            S_RLOAD:  ctrl.op = OP_RLOAD;
            S_ROOT:   ctrl.op = OP_RSTEP;
            S_OUT:    ctrl.op = out_free ? OP_CLEAR : OP_NONE;
            default:  ctrl.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sc_reg    <= '0;
            bc_reg    <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sc_reg    <= sc_next;
            bc_reg    <= bc_next;
            step_reg  <= step_next;
        end
    end

    // axis lanes
    assign samples[0] = smp.accel_x;
    assign samples[1] = smp.accel_y;
    assign samples[2] = smp.accel_z;
    assign samples[3] = smp.gyro_x;
    assign samples[4] = smp.gyro_y;
    assign samples[5] = smp.gyro_z;

    for (genvar a = 0; a < AXES; a++)
    begin : g_lane
        alldev_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .sample  (samples[a]),
            .divisor (divisor),
            .root    (roots[a])
        );
    end

    // merge lane roots into the result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (state_reg == S_OUT && out_free)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            for (int f = 0; f < OUT_FIELDS; f++)
                std_reg[f] <= (f < AXES) ? roots[f] : '0;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.accel_std_x = std_reg[0];
    assign res.accel_std_y = std_reg[1];
    assign res.accel_std_z = std_reg[2];
    assign res.gyro_std_x  = std_reg[3];
    assign res.gyro_std_y  = std_reg[4];
    assign res.gyro_std_z  = std_reg[5];

    `ALD_ASSERT_NEXT(a_div_done, clk, rst_n,
        state_reg == S_MDIV && step_reg == STEP_W'(DIV_STEPS - 1), state_reg == S_SQUARE)
    `ALD_ASSERT_NEXT(a_out_hold, clk, rst_n,
        state_reg == S_OUT && res_valid_reg && !res.ready, state_reg == S_OUT)
    `ALD_ASSERT_NEXT(a_restart_clears, clk, rst_n,
        accept && smp.restart, bc_reg == '0 && sc_reg == LEN_W'(1))
endmodule
`default_nettype wire

@@ test/allan_deviation_six_axis_top_tb.sv @@
// testbench for the six-axis allan deviation block: stimulus, prediction and checking
`timescale 1ns / 100ps
`default_nettype none

module allan_deviation_six_axis_top_tb;
    import alldev_pkg::*;

    // one imu sample and one deviation word
    typedef struct {
        bit      restart;
        sample_t axis[AXES];
    } imu_word_t;

    typedef struct {
        logic [31:0] dev[OUT_FIELDS];
    } dev_word_t;

    // predicts deviation words from accepted samples and checks the output words
    class allan_scoreboard;
        logic [LEN_W-1:0]   cluster_len;
        logic [CNT_W-1:0]   cluster_cnt;
        longint             run_sum[AXES];
        longint             last_mean[AXES];
        longint unsigned    sq_acc[AXES];
        logic [LEN_W-1:0]   taken;
        logic [CNT_W-1:0]   closed;
        dev_word_t          due_q[$];
        int                 mismatches;
        string              field_name[OUT_FIELDS];

        function new();
            cluster_len = LEN_RESET;
            cluster_cnt = CNT_RESET;
            mismatches  = 0;
            field_name  = '{"accel_std_x", "accel_std_y", "accel_std_z",
                            "gyro_std_x", "gyro_std_y", "gyro_std_z"};
            clear_run();
        endfunction

        function void clear_run();
            for (int a = 0; a < AXES; a++)
            begin
                run_sum[a]   = 0;
                last_mean[a] = 0;
                sq_acc[a]    = 0;
            end
            taken  = '0;
            closed = '0;
        endfunction

        function void set_reg(logic [ADDR_W-1:0] addr, logic [31:0] value);
            if (addr == ADDR_LEN)
                cluster_len = value[LEN_W-1:0];
            else if (addr == ADDR_CNT)
                cluster_cnt = value[CNT_W-1:0];
        endfunction

        function longint unsigned floor_root(longint unsigned x);
            longint unsigned root;
            longint unsigned b;
            root = 0;
            b = 64'h4000_0000_0000_0000;
            while (b > x)
                b = b >> 2;
            while (b != 0)
            begin
                if (x >= root + b)
                begin
                    x = x - (root + b);
                    root = (root >> 1) + b;
                end
                else
                    root = root >> 1;
                b = b >> 2;
            end
            return root;
        endfunction

        // accepted sample: update the running analysis, queue a word at its end
        function void note_sample(imu_word_t s);
            longint          eff_len;
            longint unsigned blocks;
            longint          mean;
            longint          d;
            longint unsigned ad;
            longint unsigned sq;
            longint unsigned q;
            dev_word_t       w;
            eff_len = (cluster_len == 0) ? 1 : longint'(cluster_len);
            blocks  = (cluster_cnt < 2) ? 2 : longint'(cluster_cnt);
            if (s.restart)
                clear_run();
            for (int a = 0; a < AXES; a++)
                run_sum[a] += longint'(s.axis[a]);
            taken = taken + 1'b1;
            if (longint'(taken) < eff_len)
                return;
            // block closes
            for (int a = 0; a < AXES; a++)
            begin
                mean = run_sum[a] / eff_len;
                if (closed > 0)
                begin
                    d  = mean - last_mean[a];
                    ad = (d < 0) ? longint'(-d) : d;
                    sq = (ad > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF_FFFF_FFFF : ad * ad;
                    sq_acc[a] = (sq_acc[a] + sq < sq_acc[a]) ?
                                64'hFFFF_FFFF_FFFF_FFFF : sq_acc[a] + sq;
                end
                last_mean[a] = mean;
                run_sum[a]   = 0;
            end
            taken  = '0;
            closed = closed + 1'b1;
            if (longint'(closed) < blocks)
                return;
            // analysis ends
            for (int a = 0; a < OUT_FIELDS; a++)
                w.dev[a] = '0;
            for (int a = 0; a < AXES; a++)
            begin
                q = sq_acc[a] / (2 * (blocks - 1));
                w.dev[a] = 32'(floor_root(q));
            end
            due_q.push_back(w);
            clear_run();
        endfunction

        function void check_result(dev_word_t got);
            dev_word_t exp_w;
            if (due_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: deviation word with none expected", $realtime);
                return;
            end
            exp_w = due_q.pop_front();
            for (int a = 0; a < OUT_FIELDS; a++)
                if (got.dev[a] !== exp_w.dev[a])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: %s expected %0d got %0d", $realtime,
                                 field_name[a], exp_w.dev[a], got.dev[a]);
                end
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    alldev_in_if  smp();
    alldev_out_if res();

    allan_deviation_six_axis_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .smp     (smp.sink),
        .res     (res.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    allan_scoreboard sb;
    int snd_idle_pct;
    int rcv_stall_pct;
    int sent;

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // receiver: check accepted words, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        dev_word_t got;
        if (!rst_n)
            res.ready <= 1'b0;
        else
        begin
            if (res.valid && res.ready)
            begin
                got.dev[0] = res.accel_std_x;
                got.dev[1] = res.accel_std_y;
                got.dev[2] = res.accel_std_z;
                got.dev[3] = res.gyro_std_x;
                got.dev[4] = res.gyro_std_y;
                got.dev[5] = res.gyro_std_z;
                sb.check_result(got);
            end
            res.ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // register write: setup then access cycle, then psel drops back to idle
    task automatic write_reg(logic [ADDR_W-1:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_reg(addr, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // wait until every deviation word has come and the lanes are quiet
    task automatic drain();
        smp.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_pressure();
        if (sent < 520)
        begin
            snd_idle_pct  = 25;
            rcv_stall_pct = 59;
        end
        else if (sent < 1040)
        begin
            snd_idle_pct  = 59;
            rcv_stall_pct = 25;
        end
        else
        begin
            snd_idle_pct  = 0;
            rcv_stall_pct = 0;
        end
    endtask

    // drive one sample word, hold until accepted
    task automatic send_sample(imu_word_t s);
        set_pressure();
        while ($urandom_range(99) < snd_idle_pct)
        begin
            smp.valid <= 1'b0;
            @(posedge clk);
        end
        smp.valid   <= 1'b1;
        smp.restart <= s.restart;
        smp.accel_x <= s.axis[0];
        smp.accel_y <= s.axis[1];
        smp.accel_z <= s.axis[2];
        smp.gyro_x  <= s.axis[3];
        smp.gyro_y  <= s.axis[4];
        smp.gyro_z  <= s.axis[5];
        do
            @(posedge clk);
        while (!smp.ready);
        sb.note_sample(s);
        sent++;
    endtask

    function automatic sample_t rand_value();
        int pick;
        pick = $urandom_range(9);
        if (pick < 5)
            return $urandom;
        else if (pick < 7)
            return $signed(32'($urandom_range(2000))) - 1000;
        else if (pick == 7)
            return 32'h7FFF_FFFF;
        else if (pick == 8)
            return 32'h8000_0000;
        return $signed(32'($urandom_range(255))) << 20;
    endfunction

    function automatic imu_word_t rand_word(int restart_pct);
        imu_word_t s;
        s.restart = ($urandom_range(99) < restart_pct);
        for (int a = 0; a < AXES; a++)
            s.axis[a] = rand_value();
        return s;
    endfunction

    function automatic imu_word_t flat_word(sample_t v, bit restart);
        imu_word_t s;
        s.restart = restart;
        for (int a = 0; a < AXES; a++)
            s.axis[a] = v;
        return s;
    endfunction

    // stimulus
    initial
    begin
        int len;
        int cnt;
        int n;
        sb = new();
        sent = 0;
        snd_idle_pct  = 25;
        rcv_stall_pct = 59;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        smp.valid   = 1'b0;
        smp.restart = 1'b0;
        smp.accel_x = '0;
        smp.accel_y = '0;
        smp.accel_z = '0;
        smp.gyro_x  = '0;
        smp.gyro_y  = '0;
        smp.gyro_z  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // full-scale swings saturate the square sums
        write_reg(ADDR_LEN, 32'd1);
        write_reg(ADDR_CNT, 32'd4);
        send_sample(flat_word(32'h7FFF_FFFF, 1'b0));
        send_sample(flat_word(32'h8000_0000, 1'b0));
        send_sample(flat_word(32'h7FFF_FFFF, 1'b0));
        send_sample(flat_word(32'h8000_0000, 1'b0));
        drain();

        // zero length acts as one, too few blocks acts as two
        write_reg(ADDR_LEN, 32'd0);
        write_reg(ADDR_CNT, 32'd0);
        send_sample(flat_word(-32'sd5, 1'b0));
        send_sample(flat_word(32'sd12, 1'b0));
        drain();
        write_reg(ADDR_CNT, 32'd1);
        send_sample(rand_word(0));
        send_sample(rand_word(0));
        drain();

        // negative samples, restart mid-analysis
        write_reg(ADDR_LEN, 32'd3);
        write_reg(ADDR_CNT, 32'd2);
        send_sample(flat_word(-32'sd7, 1'b0));
        send_sample(flat_word(32'sd9, 1'b1));
        send_sample(flat_word(-32'sd8, 1'b0));
        send_sample(flat_word(-32'sd1, 1'b0));
        send_sample(flat_word(32'sd100, 1'b0));
        send_sample(flat_word(32'sd4, 1'b0));
        send_sample(flat_word(32'sd0, 1'b0));
        drain();

        // longest block, then shortened while samples are held
        write_reg(ADDR_LEN, 32'hABCD_FFFF);
        for (int i = 0; i < 4; i++)
            send_sample(rand_word(0));
        drain();
        write_reg(ADDR_LEN, 32'd2);
        write_reg(ADDR_CNT, 32'hFFFF_F002);
        send_sample(rand_word(0));
        send_sample(rand_word(0));
        send_sample(rand_word(0));
        drain();

        // most blocks, then cut short mid-analysis
        write_reg(ADDR_LEN, 32'd1);
        write_reg(ADDR_CNT, 32'd4095);
        for (int i = 0; i < 5; i++)
            send_sample(rand_word(0));
        drain();
        write_reg(ADDR_CNT, 32'd3);
        send_sample(rand_word(0));
        drain();

        // random analyses, mostly short clusters
        while (sent < 1550)
        begin
            if ($urandom_range(9) < 8)
                len = $urandom_range(6, 1);
            else
                len = $urandom_range(40, 7);
            cnt = ($urandom_range(9) < 8) ? $urandom_range(5, 2) : $urandom_range(12, 6);
            write_reg(ADDR_LEN, {16'($urandom), 16'(len)});
            write_reg(ADDR_CNT, {20'($urandom), 12'(cnt)});
            n = len * cnt * $urandom_range(3, 1) + $urandom_range(len);
            if (n > 1560 - sent)
                n = 1560 - sent;
            for (int i = 0; i < n; i++)
                send_sample(rand_word(2));
            drain();
        end

        drain();
        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // timeout
    initial
    begin
        #10ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

`default_nettype wire

@@ sim.f @@
+incdir+src
src/alldev_pkg.sv
src/alldev_if.sv
src/alldev_lane.sv
src/allan_deviation_six_axis_top.sv
test/allan_deviation_six_axis_top_tb.sv
